// ===== design/rsmd_pkg.sv =====
`default_nettype none

package rsmd_pkg;

  // Config register indexes
  typedef enum logic [1:0] {
    REG_SPEED       = 2'd0,
    REG_SEPARATION  = 2'd1,
    REG_PHASE_SCALE = 2'd2
  } cfg_index_t;

  // Frame sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SINE,
    ST_CALC,
    ST_ADDR,
    ST_MAC,
    ST_GAIN,
    ST_DONE
  } seq_state_t;

  // Per-lane strobes from the sequencer
  typedef struct packed {
    logic wr_en;    // store incoming sample at write pointer
    logic rd_en;    // fetch both interpolation taps
    logic lo_ok;    // lower tap has been written since reset
    logic hi_ok;    // upper tap has been written since reset
    logic mac_en;   // linear interpolation
    logic gain_en;  // amplitude modulation
  } lane_ctrl_t;

  // Quarter-wave sine polynomial, Q.16
  localparam int SIN_A   = 102944;
  localparam int SIN_B   = 42334;
  localparam int SIN_C   = 5223;
  localparam int SIN_MAX = 32767;

  // LFO rates, Q.16 Hz
  localparam int HORN_SPEED_MUL = 6;
  localparam int HORN_BASE      = 32768;
  localparam int BASS_SPEED_MUL = 52429;
  localparam int BASS_BASE      = 6554;

  localparam int DELAY_BASE_Q8 = 1024;
  localparam int GAIN_UNITY    = 131072;
  localparam int ROUND_HALF    = 33554432;

  // Register reset values
  localparam logic [15:0] SPEED_RST       = 16'd32768;
  localparam logic [15:0] SEPARATION_RST  = 16'd32768;
  localparam logic [20:0] PHASE_SCALE_RST = 21'd89478;

endpackage

`default_nettype wire

// ===== design/rsmd_sine.sv =====
`default_nettype none

// Six-stage quantized sine: phase (Q0.32 turns) -> Q1.15.
module rsmd_sine import rsmd_pkg::*; #(
  parameter int SINE_BITS = 10
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [31:0]        phase,
  output logic                    done,
  output logic signed [15:0]      value
);

  localparam int LOW_BITS = 32 - SINE_BITS;

  logic [31:0] ang;
  logic [16:0] x_in;
  logic [5:0]  vld;

  logic [16:0] x0, x1, x2r, x3;
  logic        neg0, neg1, neg2, neg3, neg4;
  logic [16:0] sq1, sq2;
  logic [12:0] t1;
  logic [15:0] t3;
  logic [17:0] y4;

  logic [33:0] sq_prod;
  logic [29:0] c_prod;
  logic [15:0] t2;
  logic [32:0] b_prod;
  logic [16:0] t4;
  logic [33:0] a_prod;
  logic [16:0] y_half;
  logic [15:0] y_cap;

  assign ang  = {phase[31 -: SINE_BITS], {LOW_BITS{1'b0}}};
  // odd quadrants mirror the argument
  assign x_in = ang[30] ? 17'(17'd65536 - {1'b0, ang[29:14]}) : {1'b0, ang[29:14]};

  assign sq_prod = 34'(x0) * 34'(x0);
  assign c_prod  = 30'(SIN_C) * 30'(sq1);
  assign t2      = 16'(SIN_B) - {3'b0, t1};
  assign b_prod  = 33'(t2) * 33'(sq2);
  assign t4      = 17'(SIN_A) - {1'b0, t3};
  assign a_prod  = 34'(x3) * 34'(t4);
  assign y_half  = y4[17:1];
  assign y_cap   = (y_half > 17'(SIN_MAX)) ? 16'(SIN_MAX) : y_half[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x0   <= x_in;
      neg0 <= ang[31];
    end
    if (vld[0]) begin
      x1   <= x0;
      neg1 <= neg0;
      sq1  <= sq_prod[32:16];
    end
    if (vld[1]) begin
      x2r  <= x1;
      neg2 <= neg1;
      sq2  <= sq1;
      t1   <= c_prod[28:16];
    end
    if (vld[2]) begin
      x3   <= x2r;
      neg3 <= neg2;
      t3   <= b_prod[31:16];
    end
    if (vld[3]) begin
      neg4 <= neg3;
      y4   <= a_prod[33:16];
    end
    if (vld[4]) begin
      value <= neg4 ? -$signed(y_cap) : $signed(y_cap);
    end
  end

  assign done = vld[5];

endmodule

`default_nettype wire

// ===== design/rsmd_lane.sv =====
`default_nettype none

// One channel: delay line, two-tap interpolation, gain, rounding.
module rsmd_lane import rsmd_pkg::*; #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  wire logic                clk,
  input  wire lane_ctrl_t          ctrl,
  input  wire logic [ADDR_W-1:0]   wr_addr,
  input  wire logic signed [15:0]  wr_data,
  input  wire logic [ADDR_W-1:0]   rd_lo,
  input  wire logic [ADDR_W-1:0]   rd_hi,
  input  wire logic [7:0]          frac,
  input  wire logic signed [18:0]  gain,
  output logic signed [15:0]       result
);

  logic [15:0] mem [0:DEPTH-1];

  logic [15:0]        lo_q, hi_q;
  logic               lo_ok_q, hi_ok_q;
  logic signed [15:0] lo_s, hi_s;
  logic signed [9:0]  w_lo, w_hi;
  logic signed [24:0] acc;
  logic signed [43:0] prod;
  logic signed [43:0] rnd;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      lo_q    <= mem[rd_lo];
      hi_q    <= mem[rd_hi];
      lo_ok_q <= ctrl.lo_ok;
      hi_ok_q <= ctrl.hi_ok;
    end
  end

  // unwritten entries read as zero
  assign lo_s = lo_ok_q ? $signed(lo_q) : 16'sd0;
  assign hi_s = hi_ok_q ? $signed(hi_q) : 16'sd0;
  assign w_lo = $signed(10'd256 - {2'b0, frac});
  assign w_hi = $signed({2'b0, frac});

  always_ff @(posedge clk) begin
    if (ctrl.mac_en) begin
      acc <= lo_s * w_lo + hi_s * w_hi;
    end
    if (ctrl.gain_en) begin
      prod <= acc * gain;
    end
  end

  // Q.41 -> Q.15, half up
  assign rnd    = prod + 44'(ROUND_HALF);
  assign result = rnd[41:26];

endmodule

`default_nettype wire

// ===== design/rotary_speaker_modulated_delay.sv =====
`default_nettype none

// Stereo rotary-speaker effect. Each stereo request (left in tdata[15:0],
// right in tdata[31:16], Q1.15) is written into its channel's delay line and
// a Q1.15 pair is returned, read from a point behind the write position that
// swings with two LFOs (horn and bass, sine, shared by both channels) and
// scaled by a gain that follows the same LFOs. Frames are handled one at a
// time: after acceptance a request passes the six-stage sine polynomial
// pipeline, then delay address, memory read, interpolation, gain multiply
// and output load, which waits while an undrained result holds the output
// register; the next request is taken only once the result is registered.
// A finished frame sits in the output register, and the next request is
// accepted meanwhile. No memory clearing pass after reset: a fill count marks
// which delay entries have been written, and unwritten entries read as zero.
// Config writes (cfg_index 0 speed, 1 separation, 2 phase_scale, others
// ignored) are always taken and belong in idle time. SINE_TABLE_SIZE must be
// a power of two; DELAY_DEPTH may be any value in 16..65536.
module rotary_speaker_modulated_delay import rsmd_pkg::*; #(
  parameter int DELAY_DEPTH     = 1024,
  parameter int SINE_TABLE_SIZE = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input frame
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // left_in [15:0], right_in [31:16]
  // output frame
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // left_out [15:0], right_out [31:16]
  // register writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [20:0] cfg_data
);

  localparam int ADDR_W    = $clog2(DELAY_DEPTH);
  localparam int SINE_BITS = $clog2(SINE_TABLE_SIZE);
  localparam int POS_W     = ADDR_W + 9;
  localparam logic [POS_W-1:0] SPAN = POS_W'(DELAY_DEPTH * 256);

  seq_state_t state, state_next;
  lane_ctrl_t ctrl;

  logic s_accept;
  logic out_load;

  // config
  logic [15:0] speed;
  logic [15:0] separation;
  logic [20:0] phase_scale;

  // persistent state
  logic [ADDR_W-1:0] wp, wp_next;
  logic [ADDR_W:0]   fill;
  logic [31:0]       horn_phase, bass_phase;

  // per-frame working registers
  logic [31:0]        bass_pre;
  logic [23:0]        horn_step;
  logic [20:0]        bass_step;
  logic [33:0]        dprod;
  logic signed [18:0] gain;
  logic [7:0]         frac_q;

  // LFO values
  logic               horn_done, bass_done;
  logic signed [15:0] horn_val, bass_val;

  // combinational helpers
  logic [18:0]       horn_rate;
  logic [39:0]       horn_prod;
  logic [15:0]       bass_rate;
  logic [36:0]       bass_prod;
  logic [17:0]       hb_sum;
  logic [11:0]       delay_q8;
  logic [POS_W-1:0]  pos_raw, pos;
  logic [ADDR_W-1:0] rd_lo, rd_hi;

  // output register
  logic               out_valid;
  logic signed [15:0] left_res, right_res;
  logic [15:0]        left_out, right_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed       <= SPEED_RST;
      separation  <= SEPARATION_RST;
      phase_scale <= PHASE_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SPEED:       speed       <= cfg_data[15:0];
        REG_SEPARATION:  separation  <= cfg_data[15:0];
        REG_PHASE_SCALE: phase_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- LFOs ----------------
  rsmd_sine #(.SINE_BITS(SINE_BITS)) u_horn_sine (
    .clk   (clk),
    .rst   (rst),
    .start (s_accept),
    .phase (horn_phase),
    .done  (horn_done),
    .value (horn_val)
  );

  rsmd_sine #(.SINE_BITS(SINE_BITS)) u_bass_sine (
    .clk   (clk),
    .rst   (rst),
    .start (s_accept),
    .phase (bass_phase),
    .done  (bass_done),
    .value (bass_val)
  );

  // Phase increments: (rate_q16 * phase_scale) >> 16
  assign horn_rate = 19'(19'(speed) * 19'(HORN_SPEED_MUL) + 19'(HORN_BASE));
  assign horn_prod = 40'(horn_rate) * 40'(phase_scale);
  assign bass_rate = 16'(bass_pre[31:16] + 16'(BASS_BASE));
  assign bass_prod = 37'(bass_rate) * 37'(phase_scale);

  // Depth term: horn offset plus twice the bass offset, both shifted to 0..65535
  assign hb_sum = {2'b0, ~horn_val[15], horn_val[14:0]} +
                  {1'b0, ~bass_val[15], bass_val[14:0], 1'b0};

  // ---------------- read address ----------------
  // delay in Q.8 samples stays well below one lap of the line
  assign delay_q8 = 12'(DELAY_BASE_Q8) + {1'b0, dprod[33:23]};
  assign pos_raw  = {1'b0, wp, 8'h00} - POS_W'(delay_q8);
  assign pos      = pos_raw[POS_W-1] ? POS_W'(pos_raw + SPAN) : pos_raw;
  assign rd_lo    = pos[ADDR_W+7:8];
  assign rd_hi    = (rd_lo == ADDR_W'(DELAY_DEPTH - 1)) ? '0 : ADDR_W'(rd_lo + 1'b1);
  assign wp_next  = (wp == ADDR_W'(DELAY_DEPTH - 1)) ? '0 : ADDR_W'(wp + 1'b1);

  // ---------------- sequencer ----------------
  assign s_accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    ctrl          = '0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE: begin
        // no request is taken while reset is held
        s_axis_tready = !rst;
        if (s_axis_tvalid && !rst) begin
          ctrl.wr_en = 1'b1;
          state_next = ST_SINE;
        end
      end
      ST_SINE: begin
        if (horn_done && bass_done) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        state_next = ST_ADDR;
      end
      ST_ADDR: begin
        ctrl.rd_en = 1'b1;
        ctrl.lo_ok = ({1'b0, rd_lo} < fill);
        ctrl.hi_ok = ({1'b0, rd_hi} < fill);
        state_next = ST_MAC;
      end
      ST_MAC: begin
        ctrl.mac_en = 1'b1;
        state_next  = ST_GAIN;
      end
      ST_GAIN: begin
        ctrl.gain_en = 1'b1;
        state_next   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // per-frame datapath
  always_ff @(posedge clk) begin
    if (s_accept) begin
      bass_pre <= 32'(speed) * 32'(BASS_SPEED_MUL);
    end
    if (state == ST_CALC) begin
      horn_step <= horn_prod[39:16];
      dprod     <= 34'(separation) * 34'(hb_sum);
      gain      <= 19'(GAIN_UNITY) + 19'(horn_val) + 19'(bass_val);
    end
    if (state == ST_ADDR) begin
      bass_step <= bass_prod[36:16];
      frac_q    <= pos[7:0];
    end
  end

  // write pointer, fill count and phases move once the frame is out
  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      fill       <= '0;
      horn_phase <= '0;
      bass_phase <= '0;
    end else if (out_load) begin
      wp         <= wp_next;
      if (fill != (ADDR_W + 1)'(DELAY_DEPTH)) begin
        fill <= fill + 1'b1;
      end
      horn_phase <= horn_phase + {8'b0, horn_step};
      bass_phase <= bass_phase + {11'b0, bass_step};
    end
  end

  // ---------------- lanes ----------------
  rsmd_lane #(.DEPTH(DELAY_DEPTH), .ADDR_W(ADDR_W)) u_lane_left (
    .clk     (clk),
    .ctrl    (ctrl),
    .wr_addr (wp),
    .wr_data ($signed(s_axis_tdata[15:0])),
    .rd_lo   (rd_lo),
    .rd_hi   (rd_hi),
    .frac    (frac_q),
    .gain    (gain),
    .result  (left_res)
  );

  rsmd_lane #(.DEPTH(DELAY_DEPTH), .ADDR_W(ADDR_W)) u_lane_right (
    .clk     (clk),
    .ctrl    (ctrl),
    .wr_addr (wp),
    .wr_data ($signed(s_axis_tdata[31:16])),
    .rd_lo   (rd_lo),
    .rd_hi   (rd_hi),
    .frac    (frac_q),
    .gain    (gain),
    .result  (right_res)
  );

  // ---------------- merge / output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_out  <= left_res;
      right_out <= right_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {right_out, left_out};

endmodule

`default_nettype wire

// ===== design/rsmd_checker.sv =====
`default_nettype none

module rsmd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  logic       s_acc, m_acc;
  logic [1:0] pending;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;

  // requests accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (s_acc && !m_acc) begin
      pending <= pending + 1'b1;
    end else if (m_acc && !s_acc) begin
      pending <= pending - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> !s_axis_tready)
    else $error("request taken while a frame is in work");

  a_backlog: assert property (@(posedge clk) disable iff (rst)
    s_acc |-> pending <= 2'd1)
    else $error("more than one undelivered result at acceptance");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_acc |-> pending != 2'd0)
    else $error("result without a request");

endmodule

bind rotary_speaker_modulated_delay rsmd_checker u_rsmd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
module tb_top;
  import rsmd_pkg::*;

  localparam int DEPTH         = 1024;             // delay line length in the dut
  localparam int SINE_BITS     = 10;               // log2 of the sine table size
  localparam int SPAN_Q8       = DEPTH * 256;      // read position wraps here, Q.8
  localparam int IDLE_PCT      = 36;               // chance of an idle cycle per side
  localparam int SETTLE_CYCLES = 24;               // quiet wait after the last drain
  localparam int PRINT_CAP     = 100;              // mismatch lines printed at most
  localparam logic [1:0] REG_UNMAPPED = 2'd3;      // index with no register behind it

  // one stereo pair as packed on tdata: left low, right high
  typedef struct packed {
    logic [15:0] right;
    logic [15:0] left;
  } stereo_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // left_in [15:0], right_in [31:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // left_out [15:0], right_out [31:16]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [20:0] cfg_data = '0;

  rotary_speaker_modulated_delay dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Rotor model: our own copy of the delay lines, LFO phases and registers.
  // ---------------------------------------------------------------------------
  logic signed [15:0] left_line  [DEPTH];
  logic signed [15:0] right_line [DEPTH];
  logic [9:0]         wr_ptr;
  logic [31:0]        horn_phase;
  logic [31:0]        bass_phase;
  logic [15:0]        speed_q16;
  logic [15:0]        depth_q16;       // separation
  logic [20:0]        phase_per_hz;    // phase_scale

  stereo_t expected_pairs[$];          // one entry per accepted request, oldest first

  bit steady = 1'b0;                   // when set neither side idles
  int frames_sent    = 0;
  int frames_checked = 0;
  int reg_writes     = 0;
  int errors         = 0;

  // Q0.32 turns to Q1.15: phase quantized to the table grid, then the odd
  // quarter-wave polynomial with every product truncated.
  function automatic longint rotor_sine(logic [31:0] phase);
    logic [31:0] angle;
    longint x, x2, t, y;
    angle = phase & (32'hFFFF_FFFF << (32 - SINE_BITS));
    x = angle[29:14];
    if (angle[30]) x = 65536 - x;      // falling quadrants mirror the ramp
    x2 = (x * x) >>> 16;
    t = SIN_B - ((SIN_C * x2) >>> 16);
    t = SIN_A - ((t * x2) >>> 16);
    y = ((x * t) >>> 16) >>> 1;
    if (y > SIN_MAX) y = SIN_MAX;
    return angle[31] ? -y : y;         // second half of the turn is negative
  endfunction

  function automatic longint lerp_taps(logic signed [15:0] lo_tap, logic signed [15:0] hi_tap,
                                       int frac);
    return longint'(lo_tap) * (256 - frac) + longint'(hi_tap) * frac;
  endfunction

  // Q.41 down to Q.15, half rounds toward plus infinity; always fits 16 bits
  function automatic logic [15:0] round_to_q15(longint acc);
    longint q;
    q = (acc + ROUND_HALF) >>> 26;
    return q[15:0];
  endfunction

  // One frame through the rotor: store, read behind the pointer, scale,
  // then move the pointer and both LFOs on.
  task automatic advance_rotor(input logic [15:0] left_in, input logic [15:0] right_in);
    longint  h, b, delay_q8, rd_q8, gain_q18, step;
    int      idx, frac, nxt;
    stereo_t want;
    left_line[wr_ptr]  = left_in;
    right_line[wr_ptr] = right_in;
    h = rotor_sine(horn_phase);
    b = rotor_sine(bass_phase);
    // four samples base; swing up to 2 from horn, 4 from bass, scaled by separation
    delay_q8 = DELAY_BASE_Q8 +
               ((longint'(depth_q16) * ((h + 32768) + 2 * (b + 32768))) >>> 23);
    rd_q8 = (longint'(wr_ptr) * 256 + SPAN_Q8 - delay_q8) % SPAN_Q8;
    idx   = int'(rd_q8 >>> 8);
    frac  = int'(rd_q8 % 256);
    nxt   = (idx + 1) % DEPTH;
    gain_q18   = GAIN_UNITY + h + b;
    want.left  = round_to_q15(lerp_taps(left_line[idx], left_line[nxt], frac) * gain_q18);
    want.right = round_to_q15(lerp_taps(right_line[idx], right_line[nxt], frac) * gain_q18);
    expected_pairs.push_back(want);
    wr_ptr = wr_ptr + 1'b1;
    step = ((HORN_SPEED_MUL * longint'(speed_q16) + HORN_BASE) * longint'(phase_per_hz)) >>> 16;
    horn_phase = horn_phase + step[31:0];
    step = ((((longint'(speed_q16) * BASS_SPEED_MUL) >>> 16) + BASS_BASE) *
            longint'(phase_per_hz)) >>> 16;
    bass_phase = bass_phase + step[31:0];
  endtask

  // ---------------------------------------------------------------------------
  // Driving side. Every task starts and ends in the step of a rising edge.
  // tvalid is never lowered at acceptance, only by an idle cycle or a drain,
  // so back-to-back requests never see two updates in one step.
  // ---------------------------------------------------------------------------
  task automatic send_frame(input logic [15:0] left_in, input logic [15:0] right_in);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {right_in, left_in};
    do begin
      @(posedge clk);
    end while (!s_axis_tready);
    advance_rotor(left_in, right_in);
    frames_sent++;
  endtask

  // Leaves cfg_valid high; the caller drops it once its writes are done.
  task automatic write_reg(input logic [1:0] idx, input logic [20:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    case (idx)
      REG_SPEED:       speed_q16    = value[15:0];
      REG_SEPARATION:  depth_q16    = value[15:0];
      REG_PHASE_SCALE: phase_per_hz = value;
      default: ;                        // unmapped index, nothing changes
    endcase
    reg_writes++;
  endtask

  task automatic apply_settings(input logic [20:0] spd, input logic [20:0] sep,
                                input logic [20:0] scale);
    write_reg(REG_SPEED, spd);
    write_reg(REG_SEPARATION, sep);
    write_reg(REG_PHASE_SCALE, scale);
    cfg_valid <= 1'b0;
  endtask

  // Every request yields exactly one result, so an empty store means idle.
  task automatic drain_frames();
    s_axis_tvalid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3:    return 16'($urandom_range(0, 511) - 256);   // near zero, both signs
      default: return 16'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Receiving side and result check.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < PRINT_CAP)
      $display("mismatch %s at result %0d: got %h expected %h",
               what, frames_checked, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    stereo_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_pairs.size() == 0) begin
        report_mismatch("unrequested result", got, '0);
      end else begin
        want = expected_pairs.pop_front();
        if (got.left !== want.left)   report_mismatch("left_out", got.left, want.left);
        if (got.right !== want.right) report_mismatch("right_out", got.right, want.right);
      end
      frames_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings; the first few results read never-written (zero) entries,
  // later ones interpolate between the first samples sent, full-scale ones first.
  task automatic test_sample_extremes();
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'h8000, 16'h7FFF);
    send_frame(16'h0000, 16'hFFFF);
    send_frame(16'hFFFF, 16'h0000);
    send_frame(16'h7FFF, 16'h7FFF);
    send_frame(16'h8000, 16'h8000);
    send_frame(16'h0001, 16'hFFFE);
    send_frame(16'h5555, 16'hAAAA);
    drain_frames();
  endtask

  // Phase scale of zero: both LFOs freeze, delay and gain stay put.
  task automatic test_zero_phase_scale();
    write_reg(REG_PHASE_SCALE, '0);
    cfg_valid <= 1'b0;
    repeat (4) send_frame(pick_sample(), pick_sample());
    drain_frames();
  endtask

  // Unmapped index is dropped; bits above a register's width are dropped.
  task automatic test_register_masking();
    write_reg(REG_UNMAPPED, 21'h1F_FFFF);
    write_reg(REG_SPEED, 21'h1F_0000 | 21'($urandom_range(0, 65535)));
    write_reg(REG_SEPARATION, 21'h1F_FFFF);
    write_reg(REG_PHASE_SCALE, 21'd1048576);
    cfg_valid <= 1'b0;
    repeat (4) send_frame(pick_sample(), pick_sample());
    drain_frames();
  endtask

  // Fastest, deepest rotor, then the slowest and shallowest.
  task automatic test_setting_extremes();
    apply_settings(21'hFFFF, 21'hFFFF, 21'h1F_FFFF);
    send_frame(16'h7FFF, 16'h7FFF);
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'h8000, 16'h8000);
    send_frame(16'h8000, 16'h7FFF);
    send_frame(16'h7FFF, 16'h7FFF);
    send_frame(16'h8000, 16'h8000);
    drain_frames();
    apply_settings('0, '0, 21'd1);
    repeat (3) send_frame(pick_sample(), pick_sample());
    drain_frames();
  endtask

  // Six settings in turn, extremes first, then random ones; the fourth runs
  // with no idle cycles on either side.
  task automatic test_random_frames(input int per_setting);
    int s, n;
    for (s = 0; s < 6; s++) begin
      case (s)
        0:       apply_settings(21'hFFFF, 21'hFFFF, 21'h1F_FFFF);
        1:       apply_settings('0, 21'hFFFF, 21'd1048576);
        default: apply_settings(21'($urandom_range(0, 65535)), 21'($urandom_range(0, 65535)),
                                ($urandom_range(0, 1) != 0)
                                  ? 21'($urandom_range(0, 21'h1F_FFFF))
                                  : 21'($urandom_range(200000, 21'h1F_FFFF)));
      endcase
      steady = (s == 3);
      for (n = 0; n < per_setting; n++) send_frame(pick_sample(), pick_sample());
      drain_frames();
    end
    steady = 1'b0;
  endtask

  initial begin
    foreach (left_line[i]) begin
      left_line[i]  = '0;
      right_line[i] = '0;
    end
    wr_ptr       = '0;
    horn_phase   = '0;
    bass_phase   = '0;
    speed_q16    = SPEED_RST;
    depth_q16    = SEPARATION_RST;
    phase_per_hz = PHASE_SCALE_RST;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_sample_extremes();
    test_zero_phase_scale();
    test_register_masking();
    test_setting_extremes();
    test_random_frames(250);

    // nothing outstanding; watch a little longer for stray results
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run covered %0d stereo frames and %0d register writes over 11 settings",
             frames_sent, reg_writes);
    $display("results checked %0d, mismatches %0d", frames_checked, errors);
    if (errors == 0 && expected_pairs.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_pairs.size());
    $display("FAIL");
    $finish;
  end

endmodule
